@@ design/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg: shared definitions for the complex arithmetic unit
// Data widths, opcodes, pipeline stage record and the saturation helpers.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int W       = DATA_WIDTH;
    localparam int PROD_W  = 2 * W;
    localparam int SUM_W   = 2 * W + 1;
    localparam int NUM_W   = SUM_W + FRAC_BITS;
    localparam int DEN_W   = 2 * W;
    localparam int CMP_W   = ((NUM_W > 3 * W) ? NUM_W : 3 * W) + 1;
    localparam int LATENCY = W + 4;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_NEG = 3'd4;
    localparam logic [2:0] OP_CMP = 3'd5;

    typedef struct packed {
        logic signed [W-1:0] val;
        logic                ovf;
    } t_sat;

    // One stage of the divide pipeline; results of the other opcodes ride along.
    typedef struct packed {
        logic                vld;
        logic [2:0]          op;
        logic signed [W-1:0] re;
        logic signed [W-1:0] im;
        logic                ovf;
        logic                eq;
        logic                dz;
        logic                sgn_re;
        logic                sgn_im;
        logic                big_re;
        logic                big_im;
        logic [DEN_W-1:0]    den;
        logic [NUM_W-1:0]    rem_re;
        logic [NUM_W-1:0]    rem_im;
        logic [W-1:0]        q_re;
        logic [W-1:0]        q_im;
    } t_dv;

    function automatic t_sat sat(input logic signed [SUM_W-1:0] v);
        t_sat s;
        logic fits;
        fits = (&v[SUM_W-1:W-1]) || (~|v[SUM_W-1:W-1]);
        s.ovf = !fits;
        if (fits) begin
            s.val = v[W-1:0];
        end else if (v[SUM_W-1]) begin
            s.val = {1'b1, {(W-1){1'b0}}};
        end else begin
            s.val = {1'b0, {(W-1){1'b1}}};
        end
        return s;
    endfunction

    // Applies the sign to an unsigned quotient and clips it to the data width.
    function automatic t_sat sat_q(input logic neg, input logic big, input logic [W-1:0] q);
        t_sat s;
        if (neg) begin
            s.ovf = big || (q[W-1] && (|q[W-2:0]));
            s.val = s.ovf ? {1'b1, {(W-1){1'b0}}} : -q;
        end else begin
            s.ovf = big || q[W-1];
            s.val = s.ovf ? {1'b0, {(W-1){1'b1}}} : q;
        end
        return s;
    endfunction

endpackage

@@ design/complex_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit: pipelined complex arithmetic in signed fixed point
// Add, subtract, multiply, divide, negate and compare on Q16.16 operands.
// ----------------------------------------------------------------------------
// The unit takes one operation in every cycle (busy is always low) and
// presents its result with o_valid after the same chain of stages for
// every opcode, so results leave in the order they were issued. The
// pipeline holds a restoring divider, which resolves one quotient bit per
// pipeline stage over 32 stages, behind a multiplier stage, a numerator and
// denominator stage and an overflow pre-check stage. The result is shown for
// one cycle only and must be taken then.
module complex_arithmetic_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      i_op,
    input  logic signed [cau_pkg::W-1:0]    i_a_re,
    input  logic signed [cau_pkg::W-1:0]    i_a_im,
    input  logic signed [cau_pkg::W-1:0]    i_b_re,
    input  logic signed [cau_pkg::W-1:0]    i_b_im,
    output logic                            o_valid,
    output logic signed [cau_pkg::W-1:0]    o_r_re,
    output logic signed [cau_pkg::W-1:0]    o_r_im,
    output logic                            o_equal,
    output logic                            o_div_zero,
    output logic                            o_overflow
);

    localparam int W     = cau_pkg::W;
    localparam int F     = cau_pkg::FRAC_BITS;
    localparam int PW    = cau_pkg::PROD_W;
    localparam int SW    = cau_pkg::SUM_W;
    localparam int NW    = cau_pkg::NUM_W;
    localparam int DW    = cau_pkg::DEN_W;
    localparam int CW    = cau_pkg::CMP_W;

    assign busy = 1'b0;

    // ---------------- Stage 1: products and the simple operations ----------
    logic                 r_s1_vld;
    logic [2:0]           r_s1_op;
    logic signed [PW-1:0] r_s1_prr, r_s1_pii, r_s1_pri, r_s1_pir, r_s1_pbb, r_s1_pqq;
    logic signed [W:0]    r_s1_sre, r_s1_sim;
    logic                 r_s1_eq;
    logic signed [W:0]    n_s1_sre, n_s1_sim;

    always_comb begin
        case (i_op)
            cau_pkg::OP_ADD: begin
                n_s1_sre = (W+1)'(i_a_re) + (W+1)'(i_b_re);
                n_s1_sim = (W+1)'(i_a_im) + (W+1)'(i_b_im);
            end
            cau_pkg::OP_SUB: begin
                n_s1_sre = (W+1)'(i_a_re) - (W+1)'(i_b_re);
                n_s1_sim = (W+1)'(i_a_im) - (W+1)'(i_b_im);
            end
            cau_pkg::OP_NEG: begin
                n_s1_sre = -((W+1)'(i_a_re));
                n_s1_sim = -((W+1)'(i_a_im));
            end
            default: begin
                n_s1_sre = '0;
                n_s1_sim = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start;
        end
        r_s1_op  <= i_op;
        r_s1_prr <= PW'(i_a_re) * PW'(i_b_re);
        r_s1_pii <= PW'(i_a_im) * PW'(i_b_im);
        r_s1_pri <= PW'(i_a_re) * PW'(i_b_im);
        r_s1_pir <= PW'(i_a_im) * PW'(i_b_re);
        r_s1_pbb <= PW'(i_b_re) * PW'(i_b_re);
        r_s1_pqq <= PW'(i_b_im) * PW'(i_b_im);
        r_s1_sre <= n_s1_sre;
        r_s1_sim <= n_s1_sim;
        r_s1_eq  <= (i_op == cau_pkg::OP_CMP) && (i_a_re == i_b_re) && (i_a_im == i_b_im);
    end

    // ---------------- Stage 2: sums, numerators and denominator ------------
    logic signed [SW-1:0] n_mre, n_mim, n_nre, n_nim;
    logic [SW-1:0]        n_mag_re, n_mag_im;
    logic [DW-1:0]        n_den;
    cau_pkg::t_sat        n_sat_re, n_sat_im;

    logic                 r_s2_vld;
    logic [2:0]           r_s2_op;
    logic signed [W-1:0]  r_s2_re, r_s2_im;
    logic                 r_s2_ovf, r_s2_eq, r_s2_sgn_re, r_s2_sgn_im;
    logic [DW-1:0]        r_s2_den;
    logic [NW-1:0]        r_s2_num_re, r_s2_num_im;

    always_comb begin
        n_mre    = SW'(r_s1_prr) - SW'(r_s1_pii);
        n_mim    = SW'(r_s1_pri) + SW'(r_s1_pir);
        n_nre    = SW'(r_s1_prr) + SW'(r_s1_pii);
        n_nim    = SW'(r_s1_pir) - SW'(r_s1_pri);
        n_mag_re = n_nre[SW-1] ? SW'(-n_nre) : SW'(n_nre);
        n_mag_im = n_nim[SW-1] ? SW'(-n_nim) : SW'(n_nim);
        n_den    = DW'($unsigned(r_s1_pbb)) + DW'($unsigned(r_s1_pqq));
        case (r_s1_op)
            cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_NEG: begin
                n_sat_re = cau_pkg::sat(SW'(r_s1_sre));
                n_sat_im = cau_pkg::sat(SW'(r_s1_sim));
            end
            cau_pkg::OP_MUL: begin
                n_sat_re = cau_pkg::sat(n_mre >>> F);
                n_sat_im = cau_pkg::sat(n_mim >>> F);
            end
            default: begin
                n_sat_re = '0;
                n_sat_im = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_op     <= r_s1_op;
        r_s2_re     <= n_sat_re.val;
        r_s2_im     <= n_sat_im.val;
        r_s2_ovf    <= n_sat_re.ovf || n_sat_im.ovf;
        r_s2_eq     <= r_s1_eq;
        r_s2_sgn_re <= n_nre[SW-1];
        r_s2_sgn_im <= n_nim[SW-1];
        r_s2_den    <= n_den;
        r_s2_num_re <= {n_mag_re, {F{1'b0}}};
        r_s2_num_im <= {n_mag_im, {F{1'b0}}};
    end

    // ---------------- Stage 3: quotient range pre-check --------------------
    // A quotient of 2^W or more always clips, so only W quotient bits are built.
    cau_pkg::t_dv r_dv [0:W];
    cau_pkg::t_dv n_dv0;
    logic [CW-1:0] n_den_top;

    always_comb begin
        n_den_top     = CW'(r_s2_den) << W;
        n_dv0.vld     = r_s2_vld;
        n_dv0.op      = r_s2_op;
        n_dv0.re      = r_s2_re;
        n_dv0.im      = r_s2_im;
        n_dv0.ovf     = r_s2_ovf;
        n_dv0.eq      = r_s2_eq;
        n_dv0.dz      = (r_s2_den == '0);
        n_dv0.sgn_re  = r_s2_sgn_re;
        n_dv0.sgn_im  = r_s2_sgn_im;
        n_dv0.big_re  = CW'(r_s2_num_re) >= n_den_top;
        n_dv0.big_im  = CW'(r_s2_num_im) >= n_den_top;
        n_dv0.den     = r_s2_den;
        n_dv0.rem_re  = r_s2_num_re;
        n_dv0.rem_im  = r_s2_num_im;
        n_dv0.q_re    = '0;
        n_dv0.q_im    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0].vld <= 1'b0;
        end else begin
            r_dv[0] <= n_dv0;
        end
    end

    // ---------------- Stages 4 to W+3: one quotient bit per stage ----------
    for (genvar k = 0; k < W; k++) begin : g_div
        localparam int BIT = W - 1 - k;
        cau_pkg::t_dv  n_dv;
        logic [CW-1:0] n_sd;
        logic [CW-1:0] n_rre, n_rim;

        always_comb begin
            n_sd  = CW'(r_dv[k].den) << BIT;
            n_rre = CW'(r_dv[k].rem_re);
            n_rim = CW'(r_dv[k].rem_im);
            n_dv  = r_dv[k];
            if (n_rre >= n_sd) begin
                n_dv.rem_re    = NW'(n_rre - n_sd);
                n_dv.q_re[BIT] = 1'b1;
            end
            if (n_rim >= n_sd) begin
                n_dv.rem_im    = NW'(n_rim - n_sd);
                n_dv.q_im[BIT] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[k+1].vld <= 1'b0;
            end else begin
                r_dv[k+1] <= n_dv;
            end
        end
    end

    // ---------------- Output stage -----------------------------------------
    cau_pkg::t_sat       n_q_re, n_q_im;
    logic                r_o_valid, r_o_equal, r_o_div_zero, r_o_overflow;
    logic signed [W-1:0] r_o_re, r_o_im;
    logic                n_o_div_zero, n_o_overflow;
    logic signed [W-1:0] n_o_re, n_o_im;

    always_comb begin
        n_q_re       = cau_pkg::sat_q(r_dv[W].sgn_re, r_dv[W].big_re, r_dv[W].q_re);
        n_q_im       = cau_pkg::sat_q(r_dv[W].sgn_im, r_dv[W].big_im, r_dv[W].q_im);
        n_o_re       = r_dv[W].re;
        n_o_im       = r_dv[W].im;
        n_o_overflow = r_dv[W].ovf;
        n_o_div_zero = 1'b0;
        if (r_dv[W].op == cau_pkg::OP_DIV) begin
            if (r_dv[W].dz) begin
                n_o_re       = '0;
                n_o_im       = '0;
                n_o_overflow = 1'b0;
                n_o_div_zero = 1'b1;
            end else begin
                n_o_re       = n_q_re.val;
                n_o_im       = n_q_im.val;
                n_o_overflow = n_q_re.ovf || n_q_im.ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_dv[W].vld;
        end
        r_o_re       <= n_o_re;
        r_o_im       <= n_o_im;
        r_o_equal    <= r_dv[W].eq;
        r_o_div_zero <= n_o_div_zero;
        r_o_overflow <= n_o_overflow;
    end

    assign o_valid    = r_o_valid;
    assign o_r_re     = r_o_re;
    assign o_r_im     = r_o_im;
    assign o_equal    = r_o_equal;
    assign o_div_zero = r_o_div_zero;
    assign o_overflow = r_o_overflow;

endmodule

@@ design/cau_checker.sv @@
// ----------------------------------------------------------------------------
// cau_checker: port-level checks for the complex arithmetic unit
// Fixed latency and consistency of the result flags.
// ----------------------------------------------------------------------------
module cau_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            start,
    input logic                            busy,
    input logic [2:0]                      i_op,
    input logic signed [cau_pkg::W-1:0]    i_a_re,
    input logic signed [cau_pkg::W-1:0]    i_a_im,
    input logic signed [cau_pkg::W-1:0]    i_b_re,
    input logic signed [cau_pkg::W-1:0]    i_b_im,
    input logic                            o_valid,
    input logic signed [cau_pkg::W-1:0]    o_r_re,
    input logic signed [cau_pkg::W-1:0]    o_r_im,
    input logic                            o_equal,
    input logic                            o_div_zero,
    input logic                            o_overflow
);

    // Every transfer in produces exactly one result a fixed time later.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(cau_pkg::LATENCY) o_valid)
        else $error("transfer in without result at fixed latency");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !start |-> ##(cau_pkg::LATENCY) !o_valid)
        else $error("result without a matching transfer in");

    a_div_zero_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_div_zero) |-> (o_r_re == '0 && o_r_im == '0 && !o_overflow && !o_equal))
        else $error("zero divisor result is not all zero");

    a_equal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_equal) |-> (o_r_re == '0 && o_r_im == '0 && !o_overflow))
        else $error("compare result carries data or overflow");

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (.*);
